### rtl/core/skt_pkg.sv
// shared codes, field widths and types for the sorted key table
`timescale 1ns / 1ps

package skt_pkg;

  // fixed field widths on the stream ports
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int KEY_IN_W    = 32;
  localparam int POS_W       = 4;
  localparam int KEY_OUT_W   = 32;
  localparam int CNT_OUT_W   = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef logic [OP_W-1:0] op_t;
  typedef logic [ST_W-1:0] status_t;

  // operation codes
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_READ   = 2'd2;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

endpackage

### rtl/core/skt_ram.sv
// generic single-clock ram, one write port, one registered read port
`timescale 1ns / 1ps

module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/sorted_key_table_unit.sv
// sorted key table: ascending signed keys in one ram, insert / remove-all / read
`timescale 1ns / 1ps

// usage
// in_* channel carries one command item: in_tuser holds the operation
// (insert, remove all equal keys, read entry at index), in_tdata the key
// and the read index. out_* channel returns exactly one result item per
// command: in_tdata-style packing of key read, entry count and removed
// count, with the status code on out_tuser.
// the entries live in a single ram with a registered read port; a
// sequencer walks it one entry per cycle, reading entry i while it writes
// the entry it read the cycle before.
// per command:
//   insert     scans from the top, shifting larger keys up
//   remove-all makes a compaction pass over all entries
//   read       waits for ram read data; full insert, bad index, empty table and
//              unused code go straight to the result
// one item is in flight at a time; a command is accepted only while idle.
// reset empties the table (count to zero) and drops any pending result;
// ram contents are left as they are and are never read before written.
// a stalled receiver holds the result in the output register; the next
// command is still accepted and runs, and waits only to hand over its
// result until the register frees up.

module sorted_key_table_unit #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [skt_pkg::IN_TDATA_W-1:0]  in_tdata,   // key[31:0], position[35:32], zero pad
  input  skt_pkg::op_t                    in_tuser,   // operation[1:0]
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [skt_pkg::OUT_TDATA_W-1:0] out_tdata,  // key_out[31:0], entry_count[36:32],
                                                      // removed_count[41:37], zero pad
  output skt_pkg::status_t                out_tuser   // status[1:0]
);

  import skt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (KEY_WIDTH > KEY_OUT_W) ? KEY_WIDTH : KEY_OUT_W;
  localparam int PAD_W = OUT_TDATA_W - KEY_OUT_W - 2 * CNT_OUT_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;   // scan down, shift larger keys up
  localparam logic [2:0] S_INS0 = 3'd2;   // key goes to the bottom slot
  localparam logic [2:0] S_REM  = 3'd3;   // compaction pass
  localparam logic [2:0] S_RD   = 3'd4;   // read data arriving
  localparam logic [2:0] S_FIN  = 3'd5;   // hand result to output register

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        n_r, n_nxt;          // stored entries
  logic [KEY_WIDTH-1:0] key_r, key_nxt;      // command key
  logic [AW-1:0]        idx_r, idx_nxt;      // entry whose read data arrives next
  logic [CW-1:0]        wp_r, wp_nxt;        // compaction write pointer
  logic [CW-1:0]        rm_r, rm_nxt;        // removed entries
  logic [KEY_OUT_W-1:0] res_key_r, res_key_nxt;
  status_t              res_st_r, res_st_nxt;

  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]   out_tdata_r, out_tdata_nxt;
  status_t                  out_tuser_r, out_tuser_nxt;

  // ram port signals
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;

  // input field split
  op_t                  in_op;
  logic [KEY_WIDTH-1:0] in_key;
  logic [POS_W-1:0]     in_pos;
  logic                 in_fire;

  // read data widened to the output key, sign kept
  logic [XW-1:0]        rd_ext;
  logic [CW-1:0]        last_idx;

  assign in_op    = in_tuser;
  assign in_key   = KEY_WIDTH'(in_tdata[KEY_IN_W-1:0]);
  assign in_pos   = in_tdata[KEY_IN_W +: POS_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire  = in_tvalid && in_tready;
  assign rd_ext   = XW'($signed(rd_data));
  assign last_idx = CW'(n_r - 1'b1);

  skt_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    wp_nxt         = wp_r;
    rm_nxt         = rm_r;
    res_key_nxt    = res_key_r;
    res_st_nxt     = res_st_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;

    // result taken by the receiver
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt     = in_key;
          rm_nxt      = '0;
          res_key_nxt = '0;
          res_st_nxt  = ST_OK;
          state_nxt   = S_FIN;
          case (in_op)
            OP_INSERT: begin
              if (n_r == CW'(CAPACITY)) begin
                res_st_nxt = ST_FULL;
              end else if (n_r == '0) begin
                // empty table: key lands in slot 0 directly
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = in_key;
                n_nxt   = CW'(1);
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(last_idx);
                idx_nxt   = AW'(last_idx);
                state_nxt = S_INS;
              end
            end
            OP_REMOVE: begin
              if (n_r != '0) begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = '0;
                wp_nxt    = '0;
                state_nxt = S_REM;
              end
            end
            OP_READ: begin
              if (32'(in_pos) < 32'(n_r)) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_pos);
                state_nxt = S_RD;
              end else begin
                res_st_nxt = ST_RANGE;
              end
            end
            default: begin
              // unused code: no change, ok result with zero key and removed count
            end
          endcase
        end
      end

      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx_r + 1'b1);
        if ($signed(rd_data) > $signed(key_r)) begin
          // larger key moves up one slot
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_INS0;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_r - 1'b1);
            idx_nxt = AW'(idx_r - 1'b1);
          end
        end else begin
          // first entry not greater: key goes right above it
          wr_data   = key_r;
          n_nxt     = CW'(n_r + 1'b1);
          state_nxt = S_FIN;
        end
      end

      S_INS0: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = key_r;
        n_nxt     = CW'(n_r + 1'b1);
        state_nxt = S_FIN;
      end

      S_REM: begin
        // write pointer never passes the read index, so no overlap
        if (rd_data == key_r) begin
          rm_nxt = CW'(rm_r + 1'b1);
        end else begin
          wr_en   = 1'b1;
          wr_addr = AW'(wp_r);
          wr_data = rd_data;
          wp_nxt  = CW'(wp_r + 1'b1);
        end
        if (CW'(idx_r) == last_idx) begin
          n_nxt     = wp_nxt;
          state_nxt = S_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_r + 1'b1);
          idx_nxt = AW'(idx_r + 1'b1);
        end
      end

      S_RD: begin
        res_key_nxt = rd_ext[KEY_OUT_W-1:0];
        state_nxt   = S_FIN;
      end

      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{PAD_W{1'b0}}, CNT_OUT_W'(rm_r), CNT_OUT_W'(n_r), res_key_r};
          out_tuser_nxt  = res_st_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      n_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      n_r          <= n_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    idx_r       <= idx_nxt;
    wp_r        <= wp_nxt;
    rm_r        <= rm_nxt;
    res_key_r   <= res_key_nxt;
    res_st_r    <= res_st_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

### rtl/core/skt_checker.sv
// port-level checks on the sorted key table, bound to the top level
`timescale 1ns / 1ps

module skt_checker #(
  parameter int CAPACITY = 16
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [skt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input skt_pkg::status_t                out_tuser
);

  import skt_pkg::*;

  // one command in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while another is in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a dropped insert only happens on a full table
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata[36:32] == CNT_OUT_W'(CAPACITY))
    else $error("full status with table not full");

  // a failed read returns no key and removes nothing
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_RANGE |-> out_tdata[31:0] == '0 && out_tdata[41:37] == '0)
    else $error("out of range result carries data");

  // removal reports only come with an ok status and no key
  a_remove_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[41:37] != '0 |-> out_tuser == ST_OK && out_tdata[31:0] == '0)
    else $error("removed count on a non-remove result");

endmodule

bind sorted_key_table_unit skt_checker #(.CAPACITY(CAPACITY)) u_skt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/sorted_key_table_unit_test.sv
// self-checking stream testbench for the sorted key table unit
`timescale 1ns / 1ps

module sorted_key_table_unit_test;
  import skt_pkg::*;

  localparam int   DEPTH        = 16;
  localparam int   RANDOM_ITEMS = 1820;
  localparam int   IDLE_LIMIT   = 2000;
  localparam int   TAIL_CYCLES  = 24;
  // code 3 has no name in the package: the unit must answer it as a no-op
  localparam op_t  OP_UNUSED    = 2'd3;

  typedef struct packed {
    logic [31:0] key_out;
    logic [4:0]  entry_count;
    logic [4:0]  removed_count;
    status_t     status;
  } table_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  op_t                    in_tuser   = OP_INSERT;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  status_t                out_tuser;

  // mirror of the table contents, updated as each command item is accepted
  logic signed [31:0] mirror_keys [DEPTH];
  int                 mirror_count = 0;
  table_result_t      pending_results [$];
  int                 fail_count  = 0;
  int                 idle_cycles = 0;
  bit                 quiet       = 1'b0;  // both sides run without gaps

  sorted_key_table_unit #(
    .CAPACITY  (DEPTH),
    .KEY_WIDTH (32)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // table behavior: applies one command to the mirror, returns the answer
  function automatic table_result_t apply_command(op_t op, logic signed [31:0] key,
                                                  logic [3:0] pos);
    table_result_t res;
    int            at;
    int            w;
    res = '0;
    case (op)
      OP_INSERT: begin
        if (mirror_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // new key goes after every entry not greater than it
          at = 0;
          while (at < mirror_count && mirror_keys[at] <= key) at++;
          for (int i = mirror_count; i > at; i--) mirror_keys[i] = mirror_keys[i-1];
          mirror_keys[at] = key;
          mirror_count++;
        end
      end
      OP_REMOVE: begin
        w = 0;
        for (int i = 0; i < mirror_count; i++) begin
          if (mirror_keys[i] == key) begin
            res.removed_count++;
          end else begin
            mirror_keys[w] = mirror_keys[i];
            w++;
          end
        end
        mirror_count = w;
      end
      OP_READ: begin
        if (pos < mirror_count) res.key_out = mirror_keys[pos];
        else res.status = ST_RANGE;
      end
      default: ;
    endcase
    res.entry_count = 5'(mirror_count);
    return res;
  endfunction

  // called at a rising edge; returns at the edge where the item is accepted
  task automatic send_cmd(op_t op, logic [31:0] key, logic [3:0] pos);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, pos, key};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_command(op, key, pos));
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_table();
    send_cmd(OP_READ, 32'h0, 4'd0);
    send_cmd(OP_READ, 32'hFFFF_FFFF, 4'd15);
    send_cmd(OP_REMOVE, 32'h0, 4'd0);
    send_cmd(OP_UNUSED, 32'hFFFF_FFFF, 4'd15);
  endtask

  // fill with extremes and duplicates, then one insert into a full table
  task automatic test_fill_to_capacity();
    logic [31:0] fill_keys [DEPTH];
    fill_keys = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h0000_0001, 32'h0000_0005, 32'h0000_0005, 32'hFFFF_FFF9,
                  32'h0000_0064, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0005,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0005, 32'hFFFF_FF00};
    foreach (fill_keys[i]) send_cmd(OP_INSERT, fill_keys[i], 4'(i));
    send_cmd(OP_INSERT, 32'h0000_002A, 4'd0);
  endtask

  task automatic test_read_and_remove();
    send_cmd(OP_READ, 32'h0, 4'd15);
    send_cmd(OP_READ, 32'h0, 4'd0);
    send_cmd(OP_REMOVE, 32'h0000_0005, 4'd3);
    send_cmd(OP_READ, 32'h0, 4'd12);
    send_cmd(OP_REMOVE, 32'h8000_0000, 4'd0);
    send_cmd(OP_REMOVE, 32'h0000_3039, 4'd9);
  endtask

  // blocks of mixed traffic over a small key pool, so duplicates and removes
  // hit often; now and then the table is cleared and flooded with one key
  task automatic test_random_traffic();
    int          sent;
    int          insert_pct;
    int          pick;
    logic [31:0] pool [6];
    logic [31:0] key;
    logic [3:0]  pos;
    op_t         op;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet      = ($urandom_range(0, 3) == 0);
      insert_pct = 30 + 15 * $urandom_range(0, 2);
      foreach (pool[i]) begin
        case ($urandom_range(0, 3))
          0:       pool[i] = 32'h8000_0000;
          1:       pool[i] = 32'h7FFF_FFFF;
          2:       pool[i] = 32'($urandom_range(0, 20)) - 32'd10;
          default: pool[i] = $urandom();
        endcase
      end
      for (int n = 0; n < 100 && sent < RANDOM_ITEMS; n++) begin
        if ($urandom_range(0, 59) == 0) begin
          // clear, fill with one key past capacity, then remove all of it
          while (mirror_count > 0) begin
            send_cmd(OP_REMOVE, mirror_keys[0], 4'($urandom()));
            sent++;
          end
          key = pool[$urandom_range(0, 5)];
          repeat (DEPTH + 1) send_cmd(OP_INSERT, key, 4'($urandom()));
          send_cmd(OP_READ, 32'($urandom()), 4'd15);
          send_cmd(OP_REMOVE, key, 4'($urandom()));
          sent += DEPTH + 3;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < insert_pct) op = OP_INSERT;
          else if (pick < insert_pct + 20) op = OP_READ;
          else if (pick < 97) op = OP_REMOVE;
          else op = OP_UNUSED;
          key = ($urandom_range(0, 2) == 0) ? $urandom() : pool[$urandom_range(0, 5)];
          if (op == OP_READ && mirror_count > 0 && $urandom_range(0, 3) != 0)
            pos = 4'($urandom_range(0, mirror_count - 1));
          else
            pos = 4'($urandom());
          send_cmd(op, key, pos);
          sent++;
        end
      end
      if ($urandom_range(0, 2) == 0) drain_results();
    end
    quiet = 1'b0;
  endtask

  // receiver: random stall before taking each result item
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // every accepted result is matched against the oldest expected one
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with none expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.key_out) begin
          $error("key_out: expected %h, got %h", want.key_out, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[36:32] !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_tdata[36:32]);
          fail_count++;
        end
        if (out_tdata[41:37] !== want.removed_count) begin
          $error("removed_count: expected %0d, got %0d", want.removed_count,
                 out_tdata[41:37]);
          fail_count++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long without any handshake means the unit is stuck
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sorted_key_table_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    drain_results();
    test_fill_to_capacity();
    test_read_and_remove();
    drain_results();
    test_random_traffic();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("sorted_key_table_unit regression: pass");
    end else begin
      $display("sorted_key_table_unit regression: fail");
    end
    $finish;
  end

endmodule
